// ===== src/arrd_pkg.sv =====
// ----------------------------------------------------------------------------
// arrd_pkg
// Shared types and constants of the archive record deframer and decrypter.
// ----------------------------------------------------------------------------
package arrd_pkg;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH      = 3'd4;

	localparam logic [5:0] KEY_LENGTH_RESET = 6'd15;

	// result kinds
	localparam logic [1:0] KIND_NAME    = 2'd0;
	localparam logic [1:0] KIND_CONTENT = 2'd1;
	localparam logic [1:0] KIND_EMPTY   = 2'd2;
	localparam logic [1:0] KIND_STATUS  = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_TRUNC   = 2'd1;
	localparam logic [1:0] ERR_BAD_LEN = 2'd2;

	// -1111 as a 32-bit word
	localparam logic [31:0] START_MARK = 32'hFFFF_FBA9;

	localparam logic [1:0] LAST_BYTE_IN_WORD = 2'd3;

	typedef enum logic [4:0] {
		PH_NAMELEN = 5'b00001,
		PH_SKIP    = 5'b00010,
		PH_NAME    = 5'b00100,
		PH_COUNT   = 5'b01000,
		PH_CONTENT = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] item_kind;
		logic       last_of_run;
		logic [1:0] error_code;
	} result_t;

endpackage

// ===== src/arrd_key.sv =====
// ----------------------------------------------------------------------------
// arrd_key
// Key length and key character registers, with the clamped key length and
// the key character lookup for the decrypt path.
// ----------------------------------------------------------------------------
module arrd_key #(
	parameter int KEY_MAX_BYTES = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [arrd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [arrd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [$clog2(KEY_MAX_BYTES)-1:0]    key_idx,
	output logic [7:0]                          key_char,
	output logic [$clog2(KEY_MAX_BYTES+1)-1:0]  key_len
);

	localparam int LEN_W = $clog2(KEY_MAX_BYTES + 1);

	logic [5:0] key_length_q;
	logic [7:0] key_q [KEY_MAX_BYTES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= arrd_pkg::KEY_LENGTH_RESET;
		end else if (cfg_we && cfg_index == arrd_pkg::REG_KEY_LENGTH) begin
			key_length_q <= cfg_data[5:0];
		end
	end

	for (genvar i = 0; i < KEY_MAX_BYTES; i++) begin : g_key
		localparam int BANK = i / 8;
		localparam int LANE = i % 8;
		localparam logic [arrd_pkg::CFG_IDX_W-1:0] MY_REG =
			arrd_pkg::CFG_IDX_W'(int'(arrd_pkg::REG_KEY_LOW) + BANK);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				key_q[i] <= 8'd0;
			end else if (cfg_we && cfg_index == MY_REG) begin
				key_q[i] <= cfg_data[LANE*8 +: 8];
			end
		end
	end

	// zero acts as one, anything past the key store acts as its size
	always_comb begin
		if (key_length_q == 6'd0) begin
			key_len = LEN_W'(1);
		end else if (int'(key_length_q) > KEY_MAX_BYTES) begin
			key_len = LEN_W'(KEY_MAX_BYTES);
		end else begin
			key_len = LEN_W'(key_length_q);
		end
	end

	assign key_char = key_q[key_idx];

endmodule

// ===== src/arrd_parse.sv =====
// ----------------------------------------------------------------------------
// arrd_parse
// Record parser state and one-beat decode: word assembly, phase tracking,
// name pass-through and content decryption.
// ----------------------------------------------------------------------------
module arrd_parse #(
	parameter int KEY_MAX_BYTES = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  logic [7:0]                          data_byte,
	input  logic                                stream_end,
	input  logic [7:0]                          key_char,
	input  logic [$clog2(KEY_MAX_BYTES+1)-1:0]  key_len,
	output logic [$clog2(KEY_MAX_BYTES)-1:0]    key_idx,
	output logic                                res_valid,
	output arrd_pkg::result_t                   res
);

	localparam int KP_W  = $clog2(KEY_MAX_BYTES);
	localparam int LEN_W = $clog2(KEY_MAX_BYTES + 1);

	arrd_pkg::phase_t phase_q, phase_d;
	logic [1:0]       biw_q, biw_d;
	logic [23:0]      wa_q, wa_d;
	logic [31:0]      left_q, left_d;
	logic [KP_W-1:0]  kp_q, kp_d;
	logic             start_q, start_d;
	logic             halted_q, halted_d;

	logic [31:0]      word;
	logic             last;
	logic [LEN_W-1:0] idx_inc;

	assign word = {data_byte, wa_q};
	assign last = (left_q <= 32'd1);

	// key index restarts when the key length shrank below it
	assign key_idx = (LEN_W'(kp_q) < key_len) ? kp_q : '0;
	assign idx_inc = LEN_W'(key_idx) + LEN_W'(1);

	always_comb begin
		phase_d   = phase_q;
		biw_d     = biw_q;
		wa_d      = wa_q;
		left_d    = left_q;
		kp_d      = kp_q;
		start_d   = start_q;
		halted_d  = halted_q;
		res_valid = 1'b0;
		res       = '0;

		if (stream_end) begin
			res_valid     = 1'b1;
			res.item_kind = arrd_pkg::KIND_STATUS;
			if (halted_q) begin
				res.error_code = arrd_pkg::ERR_BAD_LEN;
			end else if (phase_q == arrd_pkg::PH_NAMELEN && biw_q == 2'd0) begin
				res.error_code = arrd_pkg::ERR_NONE;
			end else begin
				res.error_code = arrd_pkg::ERR_TRUNC;
			end
			phase_d  = arrd_pkg::PH_NAMELEN;
			biw_d    = 2'd0;
			wa_d     = '0;
			left_d   = '0;
			kp_d     = '0;
			start_d  = 1'b1;
			halted_d = 1'b0;
		end else if (halted_q) begin
			// drop bytes until the end of the archive
		end else if (phase_q == arrd_pkg::PH_NAME) begin
			left_d          = left_q - 32'd1;
			res_valid       = 1'b1;
			res.out_byte    = data_byte;
			res.item_kind   = arrd_pkg::KIND_NAME;
			res.last_of_run = last;
			if (last) begin
				phase_d = arrd_pkg::PH_COUNT;
			end
		end else if (biw_q != arrd_pkg::LAST_BYTE_IN_WORD) begin
			unique case (biw_q)
				2'd0:    wa_d[7:0]   = data_byte;
				2'd1:    wa_d[15:8]  = data_byte;
				default: wa_d[23:16] = data_byte;
			endcase
			biw_d = biw_q + 2'd1;
		end else begin
			biw_d = 2'd0;
			unique case (phase_q)
				arrd_pkg::PH_SKIP: begin
					phase_d = arrd_pkg::PH_NAMELEN;
				end
				arrd_pkg::PH_NAMELEN: begin
					start_d = 1'b0;
					if (start_q && word == arrd_pkg::START_MARK) begin
						phase_d = arrd_pkg::PH_SKIP;
					end else if (word[31]) begin
						halted_d       = 1'b1;
						res_valid      = 1'b1;
						res.item_kind  = arrd_pkg::KIND_STATUS;
						res.error_code = arrd_pkg::ERR_BAD_LEN;
					end else if (word == 32'd0) begin
						phase_d = arrd_pkg::PH_COUNT;
					end else begin
						left_d  = word;
						phase_d = arrd_pkg::PH_NAME;
					end
				end
				arrd_pkg::PH_COUNT: begin
					if (word == 32'd0 || word[31]) begin
						phase_d       = arrd_pkg::PH_NAMELEN;
						res_valid     = 1'b1;
						res.item_kind = arrd_pkg::KIND_EMPTY;
					end else begin
						left_d  = word;
						kp_d    = '0;
						phase_d = arrd_pkg::PH_CONTENT;
					end
				end
				arrd_pkg::PH_CONTENT: begin
					// only the first byte of the word carries data
					res_valid       = 1'b1;
					res.out_byte    = wa_q[7:0] - key_char;
					res.item_kind   = arrd_pkg::KIND_CONTENT;
					res.last_of_run = last;
					left_d          = left_q - 32'd1;
					kp_d            = (idx_inc >= key_len) ? '0 : KP_W'(idx_inc);
					if (last) begin
						phase_d = arrd_pkg::PH_NAMELEN;
						kp_d    = '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= arrd_pkg::PH_NAMELEN;
			biw_q    <= 2'd0;
			wa_q     <= '0;
			left_q   <= '0;
			kp_q     <= '0;
			start_q  <= 1'b1;
			halted_q <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			biw_q    <= biw_d;
			wa_q     <= wa_d;
			left_q   <= left_d;
			kp_q     <= kp_d;
			start_q  <= start_d;
			halted_q <= halted_d;
		end
	end

endmodule

// ===== src/archive_record_deframe_decrypt.sv =====
// ----------------------------------------------------------------------------
// archive_record_deframe_decrypt
// Byte-stream record deframer with per-word key subtraction on content.
// ----------------------------------------------------------------------------
// Takes one archive byte per beat and sustains one beat per cycle on the input
// side while the output is not stalled. A byte passes an input register, is
// decoded combinationally against the parser state and lands in the result
// register when it fires; the parser state update on each fired byte is what
// sets the rate. Bytes that complete no record field give no result. The input
// register still takes one more beat while a finished result waits on a stalled
// output, then stalls. Write the key registers only while the block is idle.
module archive_record_deframe_decrypt #(
	parameter int KEY_MAX_BYTES = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       data_byte,
	input  logic                             stream_end,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_byte,
	output logic [1:0]                       item_kind,
	output logic                             last_of_run,
	output logic [1:0]                       error_code,
	input  logic                             cfg_we,
	input  logic [arrd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [arrd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int KP_W  = $clog2(KEY_MAX_BYTES);
	localparam int LEN_W = $clog2(KEY_MAX_BYTES + 1);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              end_s1;
	logic              valid_s2;
	arrd_pkg::result_t res_s2;

	logic              s2_ready;
	logic              fire;
	logic              res_valid;
	arrd_pkg::result_t res;
	logic [KP_W-1:0]   key_idx;
	logic [7:0]        key_char;
	logic [LEN_W-1:0]  key_len;

	assign s2_ready = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && s2_ready;
	assign in_stall = valid_s1 && !s2_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			end_s1  <= stream_end;
		end
	end

	arrd_key #(
		.KEY_MAX_BYTES(KEY_MAX_BYTES)
	) u_key (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.key_idx  (key_idx),
		.key_char (key_char),
		.key_len  (key_len)
	);

	arrd_parse #(
		.KEY_MAX_BYTES(KEY_MAX_BYTES)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (byte_s1),
		.stream_end(end_s1),
		.key_char  (key_char),
		.key_len   (key_len),
		.key_idx   (key_idx),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && fire && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign out_byte    = res_s2.out_byte;
	assign item_kind   = res_s2.item_kind;
	assign last_of_run = res_s2.last_of_run;
	assign error_code  = res_s2.error_code;

endmodule
